// ===== sv/sdra_pkg.sv =====
`timescale 1ns / 1ps
package sdra_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TEMP_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP_LEVEL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_HUM_LEVEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_HUM_LEVEL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_DELTA       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_DELTA        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_HYSTERESIS = 3'd7;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_FAILED = 1'b1;

	localparam logic [14:0] TEMP_DELTA_RST = 15'd30;
	localparam logic [13:0] HUM_DELTA_RST  = 14'd200;
	localparam logic [15:0] TEMP_HYST_RST  = 16'd500;
	localparam logic [15:0] HUM_HYST_RST   = 16'd500;

	typedef struct packed {
		logic [3:0]         alarm_enable;
		logic signed [15:0] high_temp_level;
		logic signed [15:0] low_temp_level;
		logic [13:0]        high_hum_level;
		logic [13:0]        low_hum_level;
		logic [14:0]        temp_delta;
		logic [13:0]        hum_delta;
		logic [15:0]        temp_hyst;
		logic [15:0]        hum_hyst;
	} cfg_t;

endpackage

// ===== sv/sdra_cfg_regs.sv =====
`timescale 1ns / 1ps
module sdra_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sdra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdra_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sdra_pkg::cfg_t                   cfg,
	output logic                             rearm
);
	import sdra_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_enable    <= '0;
			cfg_q.high_temp_level <= '0;
			cfg_q.low_temp_level  <= '0;
			cfg_q.high_hum_level  <= '0;
			cfg_q.low_hum_level   <= '0;
			cfg_q.temp_delta      <= TEMP_DELTA_RST;
			cfg_q.hum_delta       <= HUM_DELTA_RST;
			cfg_q.temp_hyst       <= TEMP_HYST_RST;
			cfg_q.hum_hyst        <= HUM_HYST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALARM_ENABLE:     cfg_q.alarm_enable    <= cfg_data[3:0];
				REG_HIGH_TEMP_LEVEL:  cfg_q.high_temp_level <= cfg_data[15:0];
				REG_LOW_TEMP_LEVEL:   cfg_q.low_temp_level  <= cfg_data[15:0];
				REG_HIGH_HUM_LEVEL:   cfg_q.high_hum_level  <= cfg_data[13:0];
				REG_LOW_HUM_LEVEL:    cfg_q.low_hum_level   <= cfg_data[13:0];
				REG_TEMP_DELTA:       cfg_q.temp_delta      <= cfg_data[14:0];
				REG_HUM_DELTA:        cfg_q.hum_delta       <= cfg_data[13:0];
				REG_ALARM_HYSTERESIS: begin
					cfg_q.temp_hyst <= cfg_data[15:0];
					cfg_q.hum_hyst  <= cfg_data[31:16];
				end
				default: ;
			endcase
		end
	end

	// level and enable writes re-arm every alarm
	always_comb begin
		rearm = 1'b0;
		if (cfg_we) begin
			case (cfg_index) inside
				REG_ALARM_ENABLE, REG_HIGH_TEMP_LEVEL, REG_LOW_TEMP_LEVEL,
				REG_HIGH_HUM_LEVEL, REG_LOW_HUM_LEVEL: rearm = 1'b1;
				default: rearm = 1'b0;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/sdra_report.sv =====
`timescale 1ns / 1ps
module sdra_report #(
	parameter int SEND_TIMEOUT_S = 600
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_fire,
	input  logic signed [15:0]   temp,
	input  logic [13:0]          hum,
	input  logic [31:0]          now_seconds,
	input  sdra_pkg::cfg_t       cfg,
	output logic                 send
);
	import sdra_pkg::*;

	localparam logic [31:0] TIMEOUT = 32'(SEND_TIMEOUT_S);

	logic signed [15:0] last_temp_q;
	logic [13:0]        last_hum_q;
	logic [31:0]        last_time_q;
	logic               has_reported_q;

	logic signed [17:0] dt;
	logic signed [17:0] dh;
	logic signed [17:0] tdel;
	logic signed [17:0] hdel;
	logic [31:0]        elapsed;

	always_comb begin
		dt      = {{2{temp[15]}}, temp} - {{2{last_temp_q[15]}}, last_temp_q};
		dh      = {4'b0, hum} - {4'b0, last_hum_q};
		tdel    = {3'b0, cfg.temp_delta};
		hdel    = {4'b0, cfg.hum_delta};
		elapsed = now_seconds - last_time_q;
		send    = !has_reported_q || (elapsed >= TIMEOUT)
			|| (dt > tdel) || (-dt > tdel) || (dh > hdel) || (-dh > hdel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_temp_q    <= '0;
			last_hum_q     <= '0;
			last_time_q    <= '0;
			has_reported_q <= 1'b0;
		end else if (sample_fire && send) begin
			last_temp_q    <= temp;
			last_hum_q     <= hum;
			last_time_q    <= now_seconds;
			has_reported_q <= 1'b1;
		end
	end

endmodule

// ===== sv/sdra_alarm.sv =====
`timescale 1ns / 1ps
module sdra_alarm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_fire,
	input  logic                 fail_fire,
	input  logic                 rearm,
	input  logic signed [15:0]   temp,
	input  logic [13:0]          hum,
	input  sdra_pkg::cfg_t       cfg,
	output logic [3:0]           raised
);
	import sdra_pkg::*;

	logic [3:0]         latched_q;
	logic [3:0]         latched_d;
	logic [3:0]         crossed;
	logic signed [17:0] back_by [4];
	logic signed [17:0] hyst [4];
	logic signed [17:0] t_x;
	logic signed [17:0] h_x;
	logic signed [17:0] hi_t;
	logic signed [17:0] lo_t;
	logic signed [17:0] hi_h;
	logic signed [17:0] lo_h;

	always_comb begin
		t_x  = {{2{temp[15]}}, temp};
		h_x  = {4'b0, hum};
		hi_t = {{2{cfg.high_temp_level[15]}}, cfg.high_temp_level};
		lo_t = {{2{cfg.low_temp_level[15]}}, cfg.low_temp_level};
		hi_h = {4'b0, cfg.high_hum_level};
		lo_h = {4'b0, cfg.low_hum_level};

		crossed[0] = t_x > hi_t;
		crossed[1] = t_x < lo_t;
		crossed[2] = h_x > hi_h;
		crossed[3] = h_x < lo_h;
		back_by[0] = hi_t - t_x;
		back_by[1] = t_x - lo_t;
		back_by[2] = hi_h - h_x;
		back_by[3] = h_x - lo_h;
		hyst[0]    = {2'b0, cfg.temp_hyst};
		hyst[1]    = {2'b0, cfg.temp_hyst};
		hyst[2]    = {2'b0, cfg.hum_hyst};
		hyst[3]    = {2'b0, cfg.hum_hyst};

		latched_d = latched_q;
		raised    = '0;
		for (int i = 0; i < 4; i++) begin
			if (crossed[i]) begin
				if (cfg.alarm_enable[i] && !latched_q[i]) begin
					latched_d[i] = 1'b1;
					raised[i]    = 1'b1;
				end
			end else if (back_by[i] > hyst[i]) begin
				latched_d[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= '0;
		end else if (rearm || fail_fire) begin
			latched_q <= '0;
		end else if (sample_fire) begin
			latched_q <= latched_d;
		end
	end

endmodule

// ===== sv/sensor_deadband_report_and_alarm_unit.sv =====
`timescale 1ns / 1ps
// path: an accepted transaction passes the input register, then the result register
// throughput: one transaction per cycle unless out_stall holds a full result register,
// as the report and alarm state is read and updated in the same stage
// reset: asynchronous, active low; clears state and pipeline valids, loads register defaults
module sensor_deadband_report_and_alarm_unit #(
	parameter int SEND_TIMEOUT_S = 600
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sdra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdra_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic signed [15:0]               sample_temp,
	input  logic [13:0]                      sample_hum,
	input  logic [31:0]                      now_seconds,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             send_report,
	output logic [3:0]                       alarm_raised,
	output logic signed [15:0]               report_temp,
	output logic [13:0]                      report_hum
);
	import sdra_pkg::*;

	cfg_t cfg;
	logic rearm;

	logic               valid_s1;
	logic               action_s1;
	logic signed [15:0] temp_s1;
	logic [13:0]        hum_s1;
	logic [31:0]        now_s1;

	logic       adv;
	logic       sample_fire;
	logic       fail_fire;
	logic       send;
	logic [3:0] raised;

	logic               out_valid_q;
	logic               send_q;
	logic [3:0]         raised_q;
	logic signed [15:0] temp_q;
	logic [13:0]        hum_q;

	assign adv         = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall    = valid_s1 && !adv;
	assign sample_fire = adv && (action_s1 == ACT_SAMPLE);
	assign fail_fire   = adv && (action_s1 == ACT_FAILED);

	sdra_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.rearm     (rearm)
	);

	sdra_report #(
		.SEND_TIMEOUT_S (SEND_TIMEOUT_S)
	) u_report (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_fire (sample_fire),
		.temp        (temp_s1),
		.hum         (hum_s1),
		.now_seconds (now_s1),
		.cfg         (cfg),
		.send        (send)
	);

	sdra_alarm u_alarm (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_fire (sample_fire),
		.fail_fire   (fail_fire),
		.rearm       (rearm),
		.temp        (temp_s1),
		.hum         (hum_s1),
		.cfg         (cfg),
		.raised      (raised)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			temp_s1   <= sample_temp;
			hum_s1    <= sample_hum;
			now_s1    <= now_seconds;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (action_s1 == ACT_FAILED) begin
				send_q   <= 1'b0;
				raised_q <= '0;
				temp_q   <= '0;
				hum_q    <= '0;
			end else begin
				send_q   <= send;
				raised_q <= raised;
				temp_q   <= temp_s1;
				hum_q    <= hum_s1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign send_report  = send_q;
	assign alarm_raised = raised_q;
	assign report_temp  = temp_q;
	assign report_hum   = hum_q;

endmodule
